FILE: sv/hvci_pkg.sv
// ----------------------------------------------------------------------------
// hvci_pkg
// Shared constants and types of the Hermite velocity curve integrator.
// ----------------------------------------------------------------------------
package hvci_pkg;

  // Fixed point format of times, weights and values
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_KEYS_DEF = 8;

  // Field widths
  localparam int unsigned TIME_W  = 17;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned LIFE_W  = 24;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned KEY_W   = TIME_W + VAL_W;

  // Internal widths
  localparam int unsigned ACC_W = 48;  // integral, 2*FRAC_BITS fraction bits
  localparam int unsigned IW    = 32;  // integral, FRAC_BITS fraction bits
  localparam int unsigned BW    = 33;  // blended integral
  localparam int unsigned SW    = 34;  // gain scaled integral
  localparam int unsigned HW    = 19;  // Hermite integral weight

  localparam logic [TIME_W-1:0] ONE = TIME_W'(1 << FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_GAIN   = 2'd1,
    REG_MIN_N  = 2'd2,
    REG_MAX_N  = 2'd3
  } reg_idx_e;

  // Input item kinds
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  // Sequencer states
  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_CSTART = 20'h00002,
    S_K0     = 20'h00004,
    S_SEG    = 20'h00008,
    S_CHK    = 20'h00010,
    S_ZSET   = 20'h00020,
    S_DIV    = 20'h00040,
    S_W1     = 20'h00080,
    S_W2     = 20'h00100,
    S_W3     = 20'h00200,
    S_MIX1   = 20'h00400,
    S_MIX2   = 20'h00800,
    S_MIX3   = 20'h01000,
    S_ADV    = 20'h02000,
    S_TAIL   = 20'h04000,
    S_CEND   = 20'h08000,
    S_BL1    = 20'h10000,
    S_BL2    = 20'h20000,
    S_BL3    = 20'h40000,
    S_OUT    = 20'h80000
  } state_e;

endpackage

FILE: sv/hvci_ram.sv
// ----------------------------------------------------------------------------
// hvci_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hvci_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hermite_velocity_curve_integrator_top.sv
// ----------------------------------------------------------------------------
// Sequencing: a load transaction writes one key. An evaluate transaction walks
//   each curve's key segments (up to two 16-step z divisions per segment
//   crossed, none for an empty curve or a skipped segment), then blends and scales.
// Throughput: one item at a time; all keys sit in one RAM, read one a cycle.
// Reset: enable 0, gain 1.0, key counts 0; key RAM contents are not cleared.
// ----------------------------------------------------------------------------
// hermite_velocity_curve_integrator_top
// Integrates two keyframed angular-velocity curves up to a given progress,
// blends, scales by gain and lifetime, and returns the negated angle.
// ----------------------------------------------------------------------------
module hermite_velocity_curve_integrator_top #(
  parameter int unsigned MAX_KEYS = hvci_pkg::MAX_KEYS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_index[2:0], key_time[19:3], key_value[43:20], progress[60:44],
  // blend_mix[77:61], lifetime[101:78], zero pad[103:102]
  input  logic [103:0] s_axis_tdata,
  // func[0], curve_sel[1]
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle[31:0]
  output logic [31:0]  m_axis_tdata
);

  localparam int unsigned F   = hvci_pkg::FRAC_BITS;
  localparam int unsigned TW  = hvci_pkg::TIME_W;
  localparam int unsigned VW  = hvci_pkg::VAL_W;
  localparam int unsigned KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW  = $clog2(MAX_KEYS + 1);
  localparam int unsigned RD  = 2 * (2 ** KW);
  localparam int unsigned RAW = KW + 1;

  // ---------------------------------------------------------------------
  // Input field unpack
  // ---------------------------------------------------------------------
  logic                 in_func, in_curve;
  logic [2:0]           in_kidx;
  logic [TW-1:0]        in_ktime, in_prog, in_mix;
  logic [VW-1:0]        in_kval;
  logic [23:0]          in_life;

  assign in_func  = s_axis_tuser[0];
  assign in_curve = s_axis_tuser[1];
  assign in_kidx  = s_axis_tdata[2:0];
  assign in_ktime = s_axis_tdata[19:3];
  assign in_kval  = s_axis_tdata[43:20];
  assign in_prog  = s_axis_tdata[60:44];
  assign in_mix   = s_axis_tdata[77:61];
  assign in_life  = s_axis_tdata[101:78];

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                 en_q;
  logic signed [23:0]   gain_q;
  logic [3:0]           nmin_q, nmax_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      gain_q <= 24'sd65536;
      nmin_q <= '0;
      nmax_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hvci_pkg::REG_ENABLE: en_q   <= cfg_data_i[0];
        hvci_pkg::REG_GAIN:   gain_q <= $signed(cfg_data_i);
        hvci_pkg::REG_MIN_N:  nmin_q <= cfg_data_i[3:0];
        hvci_pkg::REG_MAX_N:  nmax_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Key RAM: {curve, slot} -> {time, value}
  // ---------------------------------------------------------------------
  hvci_pkg::state_e      state_q;
  logic                  ram_we;
  logic [RAW-1:0]        ram_waddr, ram_raddr;
  logic [hvci_pkg::KEY_W-1:0] ram_rdata;
  logic [TW-1:0]         rd_t;
  logic signed [VW-1:0]  rd_v;
  logic                  s_acc;

  assign s_axis_tready = (state_q == hvci_pkg::S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign ram_we        = s_acc && (in_func == hvci_pkg::FUNC_LOAD) &&
                         (32'(in_kidx) < MAX_KEYS);
  assign ram_waddr     = {in_curve, KW'(in_kidx)};
  assign rd_t          = ram_rdata[hvci_pkg::KEY_W-1:VW];
  assign rd_v          = $signed(ram_rdata[VW-1:0]);

  hvci_ram #(
    .WIDTH (hvci_pkg::KEY_W),
    .DEPTH (RD)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_ktime, in_kval}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  logic [TW-1:0]  p_q, mix_q, from_q, ta_q, tb_q, s_q, e_q, dt_q, z_q;
  logic [TW-1:0]  z2_q, z3_q, rem_q;
  logic [F-1:0]   quo_q;
  logic [3:0]     cnt_q;
  logic [23:0]    life_q;
  logic signed [VW-1:0] va_q, vb_q;
  logic           curve_q, ph_q;
  logic [CW-1:0]  i_q, n_q;
  logic signed [hvci_pkg::HW-1:0] ha0_q, hb0_q, ha1_q, hb1_q;
  logic signed [43:0] p1_q, p2_q;
  logic signed [28:0] mixs_q;
  logic signed [hvci_pkg::ACC_W-1:0] acc_q;
  logic signed [hvci_pkg::IW-1:0] imin_q, imax_q;
  logic signed [hvci_pkg::BW-1:0] blend_q;
  logic signed [hvci_pkg::SW-1:0] scaled_q;
  logic [31:0]    res_q;
  logic           mv_q;
  logic [31:0]    md_q;

  // ---------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------
  logic [3:0]     cnt_sel;
  logic [CW-1:0]  n_sel, i_nxt;
  logic [TW-1:0]  from_k0, s_c, e_c, dt_c, znum_t;
  logic signed [TW:0] znum;
  logic [TW:0]    rem2;
  logic [33:0]    zsq;
  logic [TW-1:0]  zmul_a, zprod;
  logic [TW-1:0]  half4;
  logic signed [hvci_pkg::HW-1:0] ha_c, hb_c;
  logic signed [44:0] mixsum;
  logic signed [hvci_pkg::IW:0] idiff;
  logic signed [50:0] bprod;
  logic signed [56:0] gprod;
  logic signed [58:0] lprod;
  logic signed [43:0] ang;
  logic           out_free;

  assign cnt_sel = curve_q ? nmax_q : nmin_q;
  assign n_sel   = (32'(cnt_sel) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(cnt_sel);
  assign i_nxt   = i_q + CW'(1);
  assign from_k0 = (p_q < rd_t) ? p_q : rd_t;
  assign s_c     = (from_q > ta_q) ? from_q : ta_q;
  assign e_c     = (p_q < tb_q) ? p_q : tb_q;
  assign dt_c    = (tb_q > ta_q) ? (tb_q - ta_q) : TW'(1);
  assign znum_t  = ph_q ? e_q : s_q;
  assign znum    = $signed({1'b0, znum_t}) - $signed({1'b0, ta_q});
  assign rem2    = {rem_q, 1'b0};

  // shared z power multiplier
  always_comb begin
    unique case (state_q)
      hvci_pkg::S_W1: zmul_a = z_q;
      hvci_pkg::S_W2: zmul_a = z2_q;
      default:        zmul_a = z3_q;
    endcase
  end
  assign zsq   = 34'(zmul_a) * 34'(z_q);
  assign zprod = zsq[F+TW-1:F];

  // Hermite integral weights from z, z^3, z^4
  assign half4 = zprod >> 1;
  assign ha_c  = $signed({2'b00, half4}) - $signed({2'b00, z3_q}) +
                 $signed({2'b00, z_q});
  assign hb_c  = $signed({2'b00, z3_q}) - $signed({2'b00, half4});

  assign mixsum = 45'(p1_q) + 45'(p2_q);
  assign idiff  = (hvci_pkg::IW+1)'(imax_q) - (hvci_pkg::IW+1)'(imin_q);
  assign bprod  = 51'(idiff) * 51'($signed({1'b0, mix_q}));
  assign gprod  = 57'(blend_q) * 57'(gain_q);
  assign lprod  = 59'(scaled_q) * 59'($signed({1'b0, life_q}));
  assign ang    = -44'($signed(lprod[58:F]));
  assign out_free = !mv_q || m_axis_tready;

  // RAM read address
  always_comb begin
    unique case (state_q)
      hvci_pkg::S_CSTART: ram_raddr = {curve_q, KW'(0)};
      hvci_pkg::S_ADV:    ram_raddr = {curve_q, i_nxt[KW-1:0]};
      default:            ram_raddr = {curve_q, i_q[KW-1:0]};
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hvci_pkg::S_IDLE;
    end else begin
      unique case (state_q)
        hvci_pkg::S_IDLE: begin
          if (s_acc && (in_func == hvci_pkg::FUNC_EVAL)) begin
            if (!en_q || (in_prog == '0) || (in_life == '0)) begin
              res_q   <= '0;
              state_q <= hvci_pkg::S_OUT;
            end else begin
              curve_q <= 1'b0;
              state_q <= hvci_pkg::S_CSTART;
            end
          end
        end
        hvci_pkg::S_CSTART: begin
          n_q <= n_sel;
          i_q <= CW'(1);
          if (n_sel == '0) begin
            acc_q   <= '0;
            state_q <= hvci_pkg::S_CEND;
          end else begin
            state_q <= hvci_pkg::S_K0;
          end
        end
        hvci_pkg::S_K0: begin
          ta_q    <= rd_t;
          va_q    <= rd_v;
          from_q  <= from_k0;
          acc_q   <= hvci_pkg::ACC_W'(rd_v * $signed({1'b0, from_k0}));
          if ((i_q < n_q) && (from_k0 < p_q)) begin
            state_q <= hvci_pkg::S_SEG;
          end else begin
            state_q <= hvci_pkg::S_TAIL;
          end
        end
        hvci_pkg::S_SEG: begin
          tb_q    <= rd_t;
          vb_q    <= rd_v;
          state_q <= hvci_pkg::S_CHK;
        end
        hvci_pkg::S_CHK: begin
          s_q  <= s_c;
          e_q  <= e_c;
          dt_q <= dt_c;
          ph_q <= 1'b0;
          // empty span: skip the segment
          state_q <= (e_c <= s_c) ? hvci_pkg::S_ADV : hvci_pkg::S_ZSET;
        end
        hvci_pkg::S_ZSET: begin
          if (znum <= 0) begin
            z_q     <= '0;
            state_q <= hvci_pkg::S_W1;
          end else if (TW'(znum) >= dt_q) begin
            z_q     <= hvci_pkg::ONE;
            state_q <= hvci_pkg::S_W1;
          end else begin
            rem_q   <= TW'(znum);
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= hvci_pkg::S_DIV;
          end
        end
        hvci_pkg::S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem2 >= {1'b0, dt_q}) begin
            rem_q <= TW'(rem2 - {1'b0, dt_q});
            quo_q <= {quo_q[F-2:0], 1'b1};
          end else begin
            rem_q <= TW'(rem2);
            quo_q <= {quo_q[F-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(F - 1)) begin
            state_q <= hvci_pkg::S_W1;
          end
          z_q <= {1'b0, quo_q[F-2:0], (rem2 >= {1'b0, dt_q})};
        end
        hvci_pkg::S_W1: begin
          z2_q    <= zprod;
          state_q <= hvci_pkg::S_W2;
        end
        hvci_pkg::S_W2: begin
          z3_q    <= zprod;
          state_q <= hvci_pkg::S_W3;
        end
        hvci_pkg::S_W3: begin
          if (!ph_q) begin
            ha0_q   <= ha_c;
            hb0_q   <= hb_c;
            ph_q    <= 1'b1;
            state_q <= hvci_pkg::S_ZSET;
          end else begin
            ha1_q   <= ha_c;
            hb1_q   <= hb_c;
            state_q <= hvci_pkg::S_MIX1;
          end
        end
        hvci_pkg::S_MIX1: begin
          p1_q    <= 44'(va_q * 20'(ha1_q - ha0_q));
          p2_q    <= 44'(vb_q * 20'(hb1_q - hb0_q));
          state_q <= hvci_pkg::S_MIX2;
        end
        hvci_pkg::S_MIX2: begin
          mixs_q  <= mixsum[44:F];
          state_q <= hvci_pkg::S_MIX3;
        end
        hvci_pkg::S_MIX3: begin
          acc_q   <= acc_q + hvci_pkg::ACC_W'(mixs_q * $signed({1'b0, dt_q}));
          from_q  <= e_q;
          state_q <= hvci_pkg::S_ADV;
        end
        hvci_pkg::S_ADV: begin
          ta_q <= tb_q;
          va_q <= vb_q;
          i_q  <= i_nxt;
          if ((i_nxt < n_q) && (from_q < p_q)) begin
            state_q <= hvci_pkg::S_SEG;
          end else begin
            state_q <= hvci_pkg::S_TAIL;
          end
        end
        hvci_pkg::S_TAIL: begin
          // hold the last key past its time
          if (p_q > from_q) begin
            acc_q <= acc_q + hvci_pkg::ACC_W'(va_q * $signed({1'b0, p_q - from_q}));
          end
          state_q <= hvci_pkg::S_CEND;
        end
        hvci_pkg::S_CEND: begin
          if (!curve_q) begin
            imin_q  <= acc_q[hvci_pkg::ACC_W-1:F];
            curve_q <= 1'b1;
            state_q <= hvci_pkg::S_CSTART;
          end else begin
            imax_q  <= acc_q[hvci_pkg::ACC_W-1:F];
            state_q <= hvci_pkg::S_BL1;
          end
        end
        hvci_pkg::S_BL1: begin
          blend_q <= hvci_pkg::BW'(imin_q) + hvci_pkg::BW'(bprod[50:F]);
          state_q <= hvci_pkg::S_BL2;
        end
        hvci_pkg::S_BL2: begin
          scaled_q <= hvci_pkg::SW'(gprod[56:F]);
          state_q  <= hvci_pkg::S_BL3;
        end
        hvci_pkg::S_BL3: begin
          if (ang > 44'sd2147483647) begin
            res_q <= 32'h7FFF_FFFF;
          end else if (ang < -44'sd2147483648) begin
            res_q <= 32'h8000_0000;
          end else begin
            res_q <= ang[31:0];
          end
          state_q <= hvci_pkg::S_OUT;
        end
        hvci_pkg::S_OUT: begin
          if (out_free) begin
            state_q <= hvci_pkg::S_IDLE;
          end
        end
        default: state_q <= hvci_pkg::S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      md_q <= '0;
    end else if ((state_q == hvci_pkg::S_OUT) && out_free) begin
      mv_q <= 1'b1;
      md_q <= res_q;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  // evaluate operands, captured on acceptance
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p_q    <= in_prog;
      mix_q  <= (in_mix > hvci_pkg::ONE) ? hvci_pkg::ONE : in_mix;
      life_q <= in_life;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

endmodule

FILE: tb/tb_hermite_velocity_curve_integrator_top.sv
// ----------------------------------------------------------------------------
// tb_hermite_velocity_curve_integrator_top
// Self-checking bench: loads keyframe curves, evaluates rotation angles and
// compares each angle with a fixed-point prediction of the curve integrals.
// ----------------------------------------------------------------------------
module tb_hermite_velocity_curve_integrator_top;

  localparam int NKEYS      = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    hvci_pkg::func_e func;
    logic        curve_sel;
    logic [2:0]  key_index;
    logic [16:0] key_time;
    logic [23:0] key_value;
    logic [16:0] progress;
    logic [16:0] blend_mix;
    logic [23:0] lifetime;
  } item_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [23:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;

  hermite_velocity_curve_integrator_top i_dut (.*);

  // Predictor state
  bit          rot_en;
  longint      rot_gain;
  int          min_n, max_n;
  longint      ktime[2][NKEYS];
  longint      kval[2][NKEYS];

  item_t       pending_items[$];
  logic [31:0] expected_angles[$];
  int          err_count;
  int          send_idle_pct, recv_idle_pct;
  bit          send_hold;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint fshift(longint x, int n);
    return x >>> n;
  endfunction

  function automatic void herm_w(longint z, output longint ha, output longint hb);
    longint z2, z3, z4, h4;
    z2 = fshift(z * z, hvci_pkg::FRAC_BITS);
    z3 = fshift(z2 * z, hvci_pkg::FRAC_BITS);
    z4 = fshift(z3 * z, hvci_pkg::FRAC_BITS);
    h4 = fshift(z4, 1);
    ha = h4 - z3 + z;
    hb = z3 - h4;
  endfunction

  function automatic longint seg_pos(longint t, longint ta, longint dt);
    longint num, z;
    num = t - ta;
    if (num <= 0) return 0;
    z = (num <<< hvci_pkg::FRAC_BITS) / dt;
    if (z > 65536) z = 65536;
    return z;
  endfunction

  // Integral of one curve from 0 to p, 2*FRAC_BITS fraction bits
  function automatic longint curve_integral(int c, int cnt, longint p);
    longint acc, from, ta, tb, s, e, dt, ha0, hb0, ha1, hb1, m;
    int n;
    n = (cnt > NKEYS) ? NKEYS : cnt;
    if (n == 0 || p <= 0) return 0;
    from = (p < ktime[c][0]) ? p : ktime[c][0];
    acc = kval[c][0] * from;
    for (int i = 1; i < n && from < p; i++) begin
      ta = ktime[c][i-1];
      tb = ktime[c][i];
      s = (from > ta) ? from : ta;
      e = (p < tb) ? p : tb;
      if (e <= s) continue;
      dt = tb - ta;
      if (dt < 1) dt = 1;
      herm_w(seg_pos(s, ta, dt), ha0, hb0);
      herm_w(seg_pos(e, ta, dt), ha1, hb1);
      m = kval[c][i-1] * (ha1 - ha0) + kval[c][i] * (hb1 - hb0);
      acc += fshift(m, hvci_pkg::FRAC_BITS) * dt;
      from = e;
    end
    if (p > from) acc += kval[c][n-1] * (p - from);
    return acc;
  endfunction

  function automatic logic [31:0] rotation_angle(item_t it);
    longint p, mx, life, imin, imax, bl, sc, ang;
    p = longint'(it.progress);
    mx = longint'(it.blend_mix);
    life = longint'(it.lifetime);
    if (mx > 65536) mx = 65536;
    if (!rot_en || p == 0 || life == 0) return '0;
    imin = fshift(curve_integral(0, min_n, p), hvci_pkg::FRAC_BITS);
    imax = fshift(curve_integral(1, max_n, p), hvci_pkg::FRAC_BITS);
    bl = imin + fshift((imax - imin) * mx, hvci_pkg::FRAC_BITS);
    sc = fshift(bl * rot_gain, hvci_pkg::FRAC_BITS);
    ang = -fshift(sc * life, hvci_pkg::FRAC_BITS);
    if (ang > 64'sd2147483647) ang = 64'sd2147483647;
    if (ang < -64'sd2147483648) ang = -64'sd2147483648;
    return ang[31:0];
  endfunction

  // Update curve state and queue an expected angle for an accepted item
  function automatic void predict(item_t it);
    if (it.func == hvci_pkg::FUNC_LOAD) begin
      ktime[it.curve_sel][it.key_index] = longint'(it.key_time);
      kval[it.curve_sel][it.key_index] = longint'($signed(it.key_value));
    end else begin
      expected_angles.insert(expected_angles.size(), rotation_angle(it));
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
    err_count++;
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict(pending_items.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          item_t nx;
          nx = pending_items[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= {nx.curve_sel, nx.func};
          s_axis_tdata  <= {2'b00, nx.lifetime, nx.blend_mix, nx.progress,
                            nx.key_value, nx.key_time, nx.key_index};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      quiet_cycles  <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected angle", m_axis_tdata, '0);
        end else begin
          logic [31:0] want;
          want = expected_angles.pop_front();
          if (m_axis_tdata !== want) report_mismatch("angle", m_axis_tdata, want);
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (pending_items.size() != 0 || expected_angles.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(hvci_pkg::reg_idx_e idx, int data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 24'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      hvci_pkg::REG_ENABLE: rot_en = data[0];
      hvci_pkg::REG_GAIN:   rot_gain = longint'($signed(24'(data)));
      hvci_pkg::REG_MIN_N:  min_n = data & 15;
      hvci_pkg::REG_MAX_N:  max_n = data & 15;
      default: ;
    endcase
  endtask

  function automatic void add_load(bit c, int idx, int t, int v);
    item_t it;
    it = '0;
    it.func = hvci_pkg::FUNC_LOAD;
    it.curve_sel = c;
    it.key_index = 3'(idx);
    it.key_time = 17'(t);
    it.key_value = 24'(v);
    it.progress = 17'($urandom);
    it.blend_mix = 17'($urandom);
    it.lifetime = 24'($urandom);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_eval(int p, int m, int l);
    item_t it;
    it = '0;
    it.func = hvci_pkg::FUNC_EVAL;
    it.curve_sel = 1'($urandom);
    it.key_index = 3'($urandom);
    it.key_time = 17'($urandom);
    it.key_value = 24'($urandom);
    it.progress = 17'(p);
    it.blend_mix = 17'(m);
    it.lifetime = 24'(l);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Sorted random curve, possibly with repeated or unsorted times
  function automatic void load_curve(bit c);
    int t, step;
    t = 0;
    for (int k = 0; k < NKEYS; k++) begin
      step = int'($urandom_range(16384));
      if ($urandom_range(9) == 0) t = int'($urandom_range(65536));
      else t = (t + step > 65536) ? 65536 : t + step;
      add_load(c, k, t, ($urandom_range(3) == 0) ? int'($urandom) :
                        int'($urandom_range(600000)) - 300000);
    end
  endfunction

  function automatic int rnd_q16();
    case ($urandom_range(5))
      0: return 0;
      1: return 65536;
      2: return int'($urandom_range(131071));
      default: return int'($urandom_range(65536));
    endcase
  endfunction

  function automatic int rnd_life();
    case ($urandom_range(4))
      0: return 0;
      1: return 24'hFFFFFF;
      default: return int'($urandom_range(16777215));
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = hvci_pkg::REG_ENABLE;
    cfg_data_i = '0;
    err_count = 0;
    send_hold = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 83;
    rot_en = 0; rot_gain = 65536; min_n = 0; max_n = 0;
    ktime = '{default: 0};
    kval = '{default: 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Disabled and empty curves give zero
    add_eval(65536, 65536, 24'hFFFFFF);
    wait_drain();
    write_reg(hvci_pkg::REG_ENABLE, 1);
    add_eval(40000, 30000, 65536);
    add_eval(0, 65536, 65536);
    wait_drain();

    // Directed keys: extreme values and times, then evaluate
    add_load(0, 0, 0, 24'h7FFFFF);
    add_load(0, 1, 65536, 24'h800000);
    add_load(1, 0, 20000, 24'h800000);
    add_load(1, 1, 20000, 24'h7FFFFF);
    add_load(1, 2, 10000, 24'h010000);
    for (int k = 2; k < NKEYS; k++) add_load(0, k, 65536, 24'h000100);
    for (int k = 3; k < NKEYS; k++) add_load(1, k, 65536, 24'hFFFF00);
    wait_drain();
    write_reg(hvci_pkg::REG_MIN_N, 2);
    write_reg(hvci_pkg::REG_MAX_N, 3);
    write_reg(hvci_pkg::REG_GAIN, 24'h7FFFFF);
    add_eval(131071, 131071, 24'hFFFFFF);
    add_eval(65536, 0, 24'hFFFFFF);
    add_eval(1, 65536, 1);
    add_eval(15000, 32768, 65536);
    add_eval(50000, 70000, 0);
    wait_drain();
    write_reg(hvci_pkg::REG_GAIN, 24'h800000);
    write_reg(hvci_pkg::REG_MIN_N, 15);
    write_reg(hvci_pkg::REG_MAX_N, 0);
    add_eval(131071, 65536, 24'hFFFFFF);
    add_eval(30000, 10000, 100000);
    wait_drain();

    // Random phases with varied settings and idling profiles
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 10) begin send_idle_pct = 83; recv_idle_pct = 34; end
      if (ph == 20) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(hvci_pkg::REG_ENABLE, int'($urandom_range(7) != 0));
      write_reg(hvci_pkg::REG_GAIN, ($urandom_range(3) == 0) ? int'($urandom) :
                                    int'($urandom_range(131072)));
      write_reg(hvci_pkg::REG_MIN_N, int'($urandom_range(15)));
      write_reg(hvci_pkg::REG_MAX_N, int'($urandom_range(15)));
      for (int n = 0; n < 27; n++) begin
        if ($urandom_range(5) == 0) load_curve(1'($urandom_range(1)));
        else if ($urandom_range(5) == 0)
          add_load(1'($urandom_range(1)), int'($urandom_range(7)), rnd_q16(),
                   int'($urandom));
        else add_eval(rnd_q16(), rnd_q16(), rnd_life());
      end
      if (ph == 5) begin
        // Hold the sender until all results are back
        while (expected_angles.size() != 0 || pending_items.size() > 40) @(posedge clk_i);
        send_hold = 1'b1;
        while (expected_angles.size() != 0) @(posedge clk_i);
        repeat (50) @(posedge clk_i);
        send_hold = 1'b0;
      end
      wait_drain();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
